/* rtl/tfp_pkg.sv */
package tfp_pkg;

  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned PTR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned RAW_W = 16;
  localparam int unsigned PROD_W = RAW_W + SIZE_W;
  localparam int unsigned SCALE_SHIFT = 10;
  localparam int unsigned SCALED_W = PROD_W - SCALE_SHIFT;
  localparam int unsigned POINT_W = 40;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] SYNC_A = 8'hC0;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'hF0;

  localparam logic [SIZE_W-1:0] WIDTH_RESET = 12'd800;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd600;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EV_TOUCH = 2'd0,
    EV_MOVE = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_COUNT,
    PH_POINTS,
    PH_END1,
    PH_END2
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL_X,
    SQ_MUL_Y,
    SQ_STORE,
    SQ_READ,
    SQ_LOAD,
    SQ_OUT
  } seq_e;

endpackage

/* rtl/tfp_if.sv */
interface tfp_byte_if;
  import tfp_pkg::*;
  logic valid;
  logic ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfp_event_if;
  import tfp_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] event_kind;
  logic [BYTE_W-1:0] column;
  logic [BYTE_W-1:0] row;
  logic [SIZE_W-1:0] x_pos;
  logic [SIZE_W-1:0] y_pos;
  logic last_of_run;
  modport source (output valid, output event_kind, output column, output row,
                  output x_pos, output y_pos, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input column, input row,
                input x_pos, input y_pos, input last_of_run, output ready);
endinterface

interface tfp_cfg_if;
  import tfp_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/touch_frame_parser.sv */
// The parser takes ordinary bytes back to back while its sequencer is idle.
// After a point's sixth byte, one shared 16x12 multiplier scales x in SQ_MUL_X, then y.
// A release event is presented in the cycle after its zero count byte is taken.
// A good end pair drains the point buffer: per event SQ_READ, SQ_LOAD, SQ_OUT until ready.
// Reset clears all control state and restores the screen size to 800 by 600.
// The point buffer is not cleared; only entries below the fill count are read.
module touch_frame_parser (
  input logic clk_i,
  input logic rst_ni,
  tfp_byte_if.sink rx_i,
  tfp_cfg_if.sink cfg_i,
  tfp_event_if.source ev_o
);
  import tfp_pkg::*;

  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;

  seq_e seq_q, seq_d;
  phase_e phase_q, phase_d;
  logic saw_first_q, saw_first_d;
  logic [BYTE_W-1:0] points_left_q, points_left_d;
  logic [2:0] byte_index_q, byte_index_d;
  logic [POINT_W-1:0] partial_q, partial_d;
  logic [BYTE_W-1:0] last_byte_q, last_byte_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic touching_q, touching_d;
  logic [PTR_W-1:0] rd_idx_q, rd_idx_d;
  event_kind_e drain_kind_q, drain_kind_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [SCALED_W-1:0] x_q, x_d;

  event_kind_e kind_q, kind_d;
  logic [BYTE_W-1:0] col_q, col_d;
  logic [BYTE_W-1:0] row_q, row_d;
  logic [SIZE_W-1:0] xo_q, xo_d;
  logic [SIZE_W-1:0] yo_q, yo_d;
  logic last_q, last_d;

  logic [POINT_W-1:0] mem [MAX_POINTS];
  logic [POINT_W-1:0] rd_data_q;
  logic mem_we;
  logic [POINT_W-1:0] wr_word;

  logic in_xfer;
  logic [BYTE_W-1:0] b;
  logic [RAW_W-1:0] raw_a;
  logic [RAW_W-1:0] raw_b;
  logic [RAW_W-1:0] mul_a;
  logic [SIZE_W-1:0] mul_b;
  logic [SCALED_W-1:0] y_scaled;
  logic keep;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready = (seq_q == SQ_IDLE);
  assign in_xfer = rx_i.valid && rx_i.ready;
  assign b = rx_i.rx_byte;

  assign ev_o.valid = (seq_q == SQ_OUT);
  assign ev_o.event_kind = kind_q;
  assign ev_o.column = col_q;
  assign ev_o.row = row_q;
  assign ev_o.x_pos = xo_q;
  assign ev_o.y_pos = yo_q;
  assign ev_o.last_of_run = last_q;

  assign raw_a = partial_q[23:8];
  assign raw_b = {partial_q[7:0], last_byte_q};
  assign mul_a = (seq_q == SQ_MUL_X) ? raw_b : raw_a;
  assign mul_b = (seq_q == SQ_MUL_X) ? width_q : height_q;
  assign y_scaled = prod_q[PROD_W-1:SCALE_SHIFT];
  assign keep = (x_q <= SCALED_W'(width_q)) && (y_scaled <= SCALED_W'(height_q))
             && (count_q < CNT_W'(MAX_POINTS));
  assign wr_word = {partial_q[39:32], partial_q[31:24], x_q[SIZE_W-1:0],
                    y_scaled[SIZE_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_WIDTH: width_q <= cfg_i.data;
        CFG_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_IDLE;
      phase_q <= PH_HUNT;
      saw_first_q <= 1'b0;
      points_left_q <= '0;
      byte_index_q <= '0;
      count_q <= '0;
      touching_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      seq_q <= seq_d;
      phase_q <= phase_d;
      saw_first_q <= saw_first_d;
      points_left_q <= points_left_d;
      byte_index_q <= byte_index_d;
      count_q <= count_d;
      touching_q <= touching_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    partial_q <= partial_d;
    last_byte_q <= last_byte_d;
    drain_kind_q <= drain_kind_d;
    prod_q <= prod_d;
    x_q <= x_d;
    kind_q <= kind_d;
    col_q <= col_d;
    row_q <= row_d;
    xo_q <= xo_d;
    yo_q <= yo_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[PTR_W-1:0]] <= wr_word;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  always_comb begin
    seq_d = seq_q;
    phase_d = phase_q;
    saw_first_d = saw_first_q;
    points_left_d = points_left_q;
    byte_index_d = byte_index_q;
    partial_d = partial_q;
    last_byte_d = last_byte_q;
    count_d = count_q;
    touching_d = touching_q;
    rd_idx_d = rd_idx_q;
    drain_kind_d = drain_kind_q;
    prod_d = prod_q;
    x_d = x_q;
    kind_d = kind_q;
    col_d = col_q;
    row_d = row_q;
    xo_d = xo_q;
    yo_d = yo_q;
    last_d = last_q;
    mem_we = 1'b0;

    case (seq_q)
      SQ_IDLE: begin
        if (in_xfer) begin
          case (phase_q)
            PH_HUNT: begin
              if (saw_first_q && (b == SYNC_B)) begin
                saw_first_d = 1'b0;
                phase_d = PH_COUNT;
              end else begin
                saw_first_d = (b == SYNC_A);
              end
            end
            PH_COUNT: begin
              count_d = '0;
              if (b == '0) begin
                kind_d = EV_RELEASE;
                col_d = '0;
                row_d = '0;
                xo_d = '0;
                yo_d = '0;
                last_d = 1'b1;
                touching_d = 1'b0;
                phase_d = PH_END1;
                seq_d = SQ_OUT;
              end else begin
                points_left_d = b;
                byte_index_d = '0;
                phase_d = PH_POINTS;
              end
            end
            PH_POINTS: begin
              if (byte_index_q < 3'd5) begin
                partial_d = {partial_q[POINT_W-BYTE_W-1:0], b};
                byte_index_d = byte_index_q + 3'd1;
              end else begin
                last_byte_d = b;
                byte_index_d = '0;
                points_left_d = points_left_q - 8'd1;
                if (points_left_q == 8'd1) begin
                  phase_d = PH_END1;
                end
                seq_d = SQ_MUL_X;
              end
            end
            PH_END1: begin
              if (b == SYNC_B) begin
                phase_d = PH_END2;
              end else begin
                count_d = '0;
                saw_first_d = 1'b0;
                phase_d = PH_HUNT;
              end
            end
            PH_END2: begin
              saw_first_d = 1'b0;
              phase_d = PH_HUNT;
              if ((b == SYNC_A) && (count_q != '0)) begin
                drain_kind_d = touching_q ? EV_MOVE : EV_TOUCH;
                touching_d = 1'b1;
                rd_idx_d = '0;
                seq_d = SQ_READ;
              end else begin
                count_d = '0;
              end
            end
            default: begin
              phase_d = PH_HUNT;
            end
          endcase
        end
      end
      SQ_MUL_X: begin
        prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
        seq_d = SQ_MUL_Y;
      end
      SQ_MUL_Y: begin
        x_d = prod_q[PROD_W-1:SCALE_SHIFT];
        prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
        seq_d = SQ_STORE;
      end
      SQ_STORE: begin
        if (keep) begin
          mem_we = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        seq_d = SQ_IDLE;
      end
      SQ_READ: begin
        seq_d = SQ_LOAD;
      end
      SQ_LOAD: begin
        kind_d = drain_kind_q;
        col_d = rd_data_q[39:32];
        row_d = rd_data_q[31:24];
        xo_d = rd_data_q[23:12];
        yo_d = rd_data_q[11:0];
        last_d = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);
        seq_d = SQ_OUT;
      end
      SQ_OUT: begin
        if (ev_o.ready) begin
          if (last_q) begin
            count_d = (kind_q == EV_RELEASE) ? count_q : '0;
            seq_d = SQ_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + PTR_W'(1);
            seq_d = SQ_READ;
          end
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tfp_checker.sv */
module tfp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic ev_valid,
  input logic ev_ready,
  input logic [1:0] ev_kind,
  input logic [7:0] ev_column,
  input logic [7:0] ev_row,
  input logic [11:0] ev_x,
  input logic [11:0] ev_y,
  input logic ev_last
);
  import tfp_pkg::*;

  // The parser never takes a byte while one of its events is still waiting.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> !(in_valid && in_ready))
    else $error("byte accepted while an event is pending");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> (ev_kind == EV_TOUCH || ev_kind == EV_MOVE || ev_kind == EV_RELEASE))
    else $error("illegal event kind");

  a_release_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid && ev_kind == EV_RELEASE) |->
      (ev_column == '0 && ev_row == '0 && ev_x == '0 && ev_y == '0 && ev_last))
    else $error("malformed release event");

  // Within a run the next event follows before any new byte is taken.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid && ev_ready && !ev_last) |=> !in_ready)
    else $error("byte accepted in the middle of a run");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid && !ev_ready) |=> (ev_valid && $stable(ev_kind) && $stable(ev_x)
      && $stable(ev_y) && $stable(ev_last)))
    else $error("stalled event changed");

endmodule

bind touch_frame_parser tfp_checker u_tfp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid(rx_i.valid),
  .in_ready(rx_i.ready),
  .ev_valid(ev_o.valid),
  .ev_ready(ev_o.ready),
  .ev_kind(ev_o.event_kind),
  .ev_column(ev_o.column),
  .ev_row(ev_o.row),
  .ev_x(ev_o.x_pos),
  .ev_y(ev_o.y_pos),
  .ev_last(ev_o.last_of_run)
);
